// ===== rtl/msc_pkg.sv =====
`timescale 1ns / 1ps

package msc_pkg;

    localparam int NUM_DIGITS  = 4;
    localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
    localparam int PERIOD_W    = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST  = 16'd100;
    localparam logic [PERIOD_W-1:0] SECOND_PERIOD_RST = 16'd100;
    localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RST   = 16'd25;

    localparam logic [4:0] HOUR_RST   = 5'd15;
    localparam logic [5:0] MINUTE_RST = 6'd8;
    localparam logic [5:0] SECOND_RST = 6'd50;

    localparam logic [5:0] SIXTY      = 6'd60;
    localparam logic [4:0] TWENTYFOUR = 5'd24;

    localparam logic [6:0] SEG_BLANK = 7'h7F;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLINK_PERIOD  = 2'd0,
        CFG_SECOND_PERIOD = 2'd1,
        CFG_SCAN_PERIOD   = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [6:0]            segments;
        logic [NUM_DIGITS-1:0] digit_enables;
        logic                  dot_led;
        logic                  red_led;
        logic [4:0]            hours_now;
        logic [5:0]            minutes_now;
        logic [5:0]            seconds_now;
    } result_t;

    // Active-low pattern, bit 0 is segment a.
    function automatic logic [6:0] seg_decode(input logic [3:0] value);
        logic [6:0] pattern;
        unique case (value)
            4'd0:    pattern = 7'h40;
            4'd1:    pattern = 7'h79;
            4'd2:    pattern = 7'h24;
            4'd3:    pattern = 7'h30;
            4'd4:    pattern = 7'h19;
            4'd5:    pattern = 7'h12;
            4'd6:    pattern = 7'h02;
            4'd7:    pattern = 7'h78;
            4'd8:    pattern = 7'h00;
            4'd9:    pattern = 7'h10;
            default: pattern = SEG_BLANK;
        endcase
        return pattern;
    endfunction

    // Values never exceed 59, so a short compare chain gives the tens digit.
    function automatic logic [3:0] tens_of(input logic [5:0] value);
        logic [3:0] tens;
        priority if (value >= 6'd50) tens = 4'd5;
        else if (value >= 6'd40)     tens = 4'd4;
        else if (value >= 6'd30)     tens = 4'd3;
        else if (value >= 6'd20)     tens = 4'd2;
        else if (value >= 6'd10)     tens = 4'd1;
        else                         tens = 4'd0;
        return tens;
    endfunction

    function automatic logic [3:0] units_of(input logic [5:0] value);
        logic [5:0] tens;
        logic [5:0] rest;
        tens = {2'b00, tens_of(value)};
        rest = value - ((tens << 3) + (tens << 1));
        return rest[3:0];
    endfunction

endpackage

// ===== rtl/multiplexed_seven_segment_clock.sv =====
`timescale 1ns / 1ps

// Four-digit multiplexed clock display driven by base ticks.
// Input channel: one item per transfer (in_valid, in_stall, tick). A tick of 1
// advances the blink, second and scan dividers by one; a tick of 0 only
// reports the current state.
// Output channel: one result per input item (out_valid, out_stall), holding
// the segment and digit-enable drive, the dot and red LED levels and the
// current hours, minutes and seconds after that item.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data set the three
// divider periods; cfg_ready is always high. A new period takes effect at the
// divider's next reload.
// Each result is registered in the output register, or in the skid register if
// that is full. Throughput is one item per cycle while in_stall is low; all state
// updates for an item happen at its input transfer. A two-entry output buffer
// (output register plus skid register) decouples the sides: in_stall rises only
// when both entries are full, after an item arrives while a stalled result waits.
// Reset loads the periods 100/100/25, the time 15:08:50, clears the digits,
// scan index, LEDs and output buffer.
module multiplexed_seven_segment_clock (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                tick,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [6:0]                          segments,
    output logic [msc_pkg::NUM_DIGITS-1:0]      digit_enables,
    output logic                                dot_led,
    output logic                                red_led,
    output logic [4:0]                          hours_now,
    output logic [5:0]                          minutes_now,
    output logic [5:0]                          seconds_now,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [msc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [msc_pkg::PERIOD_W-1:0]        cfg_data
);
    import msc_pkg::*;

    localparam logic [NUM_DIGITS-1:0]  ENABLE_ONE = NUM_DIGITS'(1);
    localparam logic [DIGIT_IDX_W-1:0] IDX_ONE    = DIGIT_IDX_W'(1);

    logic [PERIOD_W-1:0] blink_period_reg, second_period_reg, scan_period_reg;
    logic [PERIOD_W-1:0] blink_count_reg, second_count_reg, scan_count_reg;
    logic [PERIOD_W-1:0] blink_count_next, second_count_next, scan_count_next;
    logic [4:0]          hour_reg, hour_next;
    logic [5:0]          minute_reg, minute_next;
    logic [5:0]          second_reg, second_next;
    logic [3:0]          digit_reg [NUM_DIGITS];
    logic [3:0]          digit_next [NUM_DIGITS];
    logic [DIGIT_IDX_W-1:0] scan_index_reg, scan_index_next;
    logic [6:0]          segment_reg, segment_next;
    logic [NUM_DIGITS-1:0] enable_reg, enable_next;
    logic                dot_reg, dot_next;
    logic                red_reg, red_next;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    result_t result;

    logic in_take, out_take, step;
    logic blink_fire, second_fire, scan_fire;
    logic [5:0] second_inc, minute_inc;
    logic [4:0] hour_inc;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_take   = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;
    assign step      = in_take && tick;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_period_reg  <= BLINK_PERIOD_RST;
            second_period_reg <= SECOND_PERIOD_RST;
            scan_period_reg   <= SCAN_PERIOD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BLINK_PERIOD:  blink_period_reg  <= cfg_data;
                CFG_SECOND_PERIOD: second_period_reg <= cfg_data;
                CFG_SCAN_PERIOD:   scan_period_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // A count of one or zero fires and reloads, so a zero period acts as one.
    assign blink_fire  = step && (blink_count_reg <= PERIOD_W'(1));
    assign second_fire = step && (second_count_reg <= PERIOD_W'(1));
    assign scan_fire   = step && (scan_count_reg <= PERIOD_W'(1));

    always_comb
    begin
        blink_count_next  = blink_count_reg;
        second_count_next = second_count_reg;
        scan_count_next   = scan_count_reg;
        if (step)
        begin
            blink_count_next  = blink_fire  ? blink_period_reg  : blink_count_reg - 1'b1;
            second_count_next = second_fire ? second_period_reg : second_count_reg - 1'b1;
            scan_count_next   = scan_fire   ? scan_period_reg   : scan_count_reg - 1'b1;
        end
    end

    assign red_next = red_reg ^ blink_fire;
    assign dot_next = dot_reg ^ second_fire;

    always_comb
    begin
        second_inc  = second_reg + 1'b1;
        minute_inc  = minute_reg;
        hour_inc    = hour_reg;
        second_next = second_reg;
        minute_next = minute_reg;
        hour_next   = hour_reg;
        if (second_inc >= SIXTY)
        begin
            second_inc = '0;
            minute_inc = minute_reg + 1'b1;
        end
        if (minute_inc >= SIXTY)
        begin
            minute_inc = '0;
            hour_inc   = hour_reg + 1'b1;
        end
        if (hour_inc >= TWENTYFOUR)
            hour_inc = '0;
        if (second_fire)
        begin
            second_next = second_inc;
            minute_next = minute_inc;
            hour_next   = hour_inc;
        end
    end

    always_comb
    begin
        digit_next = digit_reg;
        if (second_fire)
        begin
            digit_next[0] = tens_of({1'b0, hour_inc});
            digit_next[1] = units_of({1'b0, hour_inc});
            digit_next[2] = tens_of(minute_inc);
            digit_next[3] = units_of(minute_inc);
        end
    end

    // The scan in the same tick already sees the freshly loaded digits.
    always_comb
    begin
        segment_next    = segment_reg;
        enable_next     = enable_reg;
        scan_index_next = scan_index_reg;
        if (scan_fire)
        begin
            segment_next    = seg_decode(digit_next[scan_index_reg]);
            enable_next     = ~(ENABLE_ONE << scan_index_reg);
            scan_index_next = scan_index_reg + IDX_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_count_reg  <= BLINK_PERIOD_RST;
            second_count_reg <= SECOND_PERIOD_RST;
            scan_count_reg   <= SCAN_PERIOD_RST;
            hour_reg         <= HOUR_RST;
            minute_reg       <= MINUTE_RST;
            second_reg       <= SECOND_RST;
            for (int i = 0; i < NUM_DIGITS; i++)
                digit_reg[i] <= '0;
            scan_index_reg   <= '0;
            segment_reg      <= '0;
            enable_reg       <= '0;
            dot_reg          <= 1'b0;
            red_reg          <= 1'b0;
        end
        else
        begin
            blink_count_reg  <= blink_count_next;
            second_count_reg <= second_count_next;
            scan_count_reg   <= scan_count_next;
            hour_reg         <= hour_next;
            minute_reg       <= minute_next;
            second_reg       <= second_next;
            digit_reg        <= digit_next;
            scan_index_reg   <= scan_index_next;
            segment_reg      <= segment_next;
            enable_reg       <= enable_next;
            dot_reg          <= dot_next;
            red_reg          <= red_next;
        end
    end

    always_comb
    begin
        result.segments      = segment_next;
        result.digit_enables = enable_next;
        result.dot_led       = dot_next;
        result.red_led       = red_next;
        result.hours_now     = hour_next;
        result.minutes_now   = minute_next;
        result.seconds_now   = second_next;
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
                out_valid_next = 1'b0;
        end
        if (in_take)
        begin
            if (!out_valid_next)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid     = out_valid_reg;
    assign segments      = out_data_reg.segments;
    assign digit_enables = out_data_reg.digit_enables;
    assign dot_led       = out_data_reg.dot_led;
    assign red_led       = out_data_reg.red_led;
    assign hours_now     = out_data_reg.hours_now;
    assign minutes_now   = out_data_reg.minutes_now;
    assign seconds_now   = out_data_reg.seconds_now;

endmodule

// ===== rtl/msc_checker.sv =====
`timescale 1ns / 1ps

module msc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [6:0]                     segments,
    input logic [msc_pkg::NUM_DIGITS-1:0] digit_enables,
    input logic                           dot_led,
    input logic                           red_led,
    input logic [4:0]                     hours_now,
    input logic [5:0]                     minutes_now,
    input logic [5:0]                     seconds_now
);
    import msc_pkg::*;

    // The input side only backs up when a result is already waiting.
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> out_valid)
        else $error("in_stall raised with no result waiting");

    // At most one digit is driven at a time, apart from the all-zero reset value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit_enables == '1) || (digit_enables == '0)
                      || $onehot(~digit_enables))
        else $error("more than one digit enabled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hours_now < 5'd24) && (minutes_now < 6'd60)
                      && (seconds_now < 6'd60))
        else $error("time out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(segments)
                                   && $stable(digit_enables) && $stable(dot_led)
                                   && $stable(red_led) && $stable(hours_now)
                                   && $stable(minutes_now) && $stable(seconds_now))
        else $error("stalled result changed");

endmodule

bind multiplexed_seven_segment_clock msc_checker u_msc_checker (.*);

// ===== verif/tb_multiplexed_seven_segment_clock.sv =====
`timescale 1ns / 1ps

module tb_multiplexed_seven_segment_clock;
    import msc_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int ITEMS_PER_PHASE = 235;
    localparam int RANDOM_PHASES   = 6;
    localparam int FAST_TAIL_ITEMS = 100;
    localparam int WIDE_TAIL_ITEMS = 10;
    localparam int SCRIPT_ROWS     = 20;

    typedef enum logic [1:0] {ROW_TICK, ROW_BURST, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic                  tick_bit;
        int unsigned           reps;
        cfg_index_t            reg_sel;
        logic [PERIOD_W-1:0]   value;
        bit                    typed;
        result_t               want;
    } script_row_t;

    localparam result_t RESET_VIEW =
        {7'h00, 4'h0, 1'b0, 1'b0, HOUR_RST, MINUTE_RST, SECOND_RST};
    // The first scan step shows digit 0 while the digit registers are still clear.
    localparam result_t FIRST_SCAN_VIEW =
        {7'h40, 4'hE, 1'b0, 1'b0, HOUR_RST, MINUTE_RST, SECOND_RST};

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  tick;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [6:0]            segments;
    logic [NUM_DIGITS-1:0] digit_enables;
    logic                  dot_led;
    logic                  red_led;
    logic [4:0]            hours_now;
    logic [5:0]            minutes_now;
    logic [5:0]            seconds_now;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_index_t            cfg_index;
    logic [PERIOD_W-1:0]   cfg_data;

    int sender_gap_pct = 18;
    int receiver_stall_pct = 83;
    int fault_count = 0;

    result_t     expected_views [$];
    script_row_t script [0:SCRIPT_ROWS-1];

    // Shadow copy of the clock state.
    logic [PERIOD_W-1:0] blink_reload;
    logic [PERIOD_W-1:0] second_reload;
    logic [PERIOD_W-1:0] scan_reload;
    logic [PERIOD_W-1:0] blink_left;
    logic [PERIOD_W-1:0] second_left;
    logic [PERIOD_W-1:0] scan_left;
    logic [4:0]          hour_q;
    logic [5:0]          minute_q;
    logic [5:0]          second_q;
    logic [3:0]          shown_digits [NUM_DIGITS];
    logic [1:0]          scan_pos;
    logic [6:0]          seg_q;
    logic [3:0]          en_q;
    logic                dot_q;
    logic                red_q;

    multiplexed_seven_segment_clock dut (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    function void flag_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endfunction

    function void reset_clock_model();
        blink_reload  = BLINK_PERIOD_RST;
        second_reload = SECOND_PERIOD_RST;
        scan_reload   = SCAN_PERIOD_RST;
        blink_left    = BLINK_PERIOD_RST;
        second_left   = SECOND_PERIOD_RST;
        scan_left     = SCAN_PERIOD_RST;
        hour_q        = HOUR_RST;
        minute_q      = MINUTE_RST;
        second_q      = SECOND_RST;
        foreach (shown_digits[i])
            shown_digits[i] = 4'd0;
        scan_pos = 2'd0;
        seg_q    = 7'h00;
        en_q     = 4'h0;
        dot_q    = 1'b0;
        red_q    = 1'b0;
    endfunction

    // A count of one or zero fires and reloads, so a period of zero acts like one.
    function automatic bit divider_expired(inout logic [PERIOD_W-1:0] left,
                                           input logic [PERIOD_W-1:0] reload);
        if (left <= 1)
        begin
            left = reload;
            return 1'b1;
        end
        left = left - 1'b1;
        return 1'b0;
    endfunction

    // Advances the shadow state by one item and returns what the block should show.
    function automatic result_t display_after(input logic t);
        logic [3:0] digit;
        if (t)
        begin
            if (divider_expired(blink_left, blink_reload))
                red_q = ~red_q;
            if (divider_expired(second_left, second_reload))
            begin
                second_q = second_q + 1'b1;
                if (second_q >= SIXTY)
                begin
                    second_q = 6'd0;
                    minute_q = minute_q + 1'b1;
                end
                if (minute_q >= SIXTY)
                begin
                    minute_q = 6'd0;
                    hour_q   = hour_q + 1'b1;
                end
                if (hour_q >= TWENTYFOUR)
                    hour_q = 5'd0;
                shown_digits[0] = 4'(hour_q / 10);
                shown_digits[1] = 4'(hour_q % 10);
                shown_digits[2] = 4'(minute_q / 10);
                shown_digits[3] = 4'(minute_q % 10);
                dot_q = ~dot_q;
            end
            // The scan runs after the clock update, so it already sees new digits.
            if (divider_expired(scan_left, scan_reload))
            begin
                digit = shown_digits[scan_pos];
                en_q  = ~(4'b0001 << scan_pos);
                case (digit)
                    4'd0:    seg_q = 7'h40;
                    4'd1:    seg_q = 7'h79;
                    4'd2:    seg_q = 7'h24;
                    4'd3:    seg_q = 7'h30;
                    4'd4:    seg_q = 7'h19;
                    4'd5:    seg_q = 7'h12;
                    4'd6:    seg_q = 7'h02;
                    4'd7:    seg_q = 7'h78;
                    4'd8:    seg_q = 7'h00;
                    4'd9:    seg_q = 7'h10;
                    default: seg_q = SEG_BLANK;
                endcase
                scan_pos = scan_pos + 1'b1;
            end
        end
        return {seg_q, en_q, dot_q, red_q, hour_q, minute_q, second_q};
    endfunction

    // Periods range from zero to 300 and are mostly six or less.
    function automatic logic [PERIOD_W-1:0] pick_period();
        case ($urandom_range(9))
            0:       return '0;
            1:       return PERIOD_W'(1);
            2, 3:    return PERIOD_W'($urandom_range(300, 7));
            default: return PERIOD_W'($urandom_range(6, 1));
        endcase
    endfunction

    task automatic send_tick(input logic t, input bit typed, input result_t want);
        result_t predicted;
        while ($urandom_range(99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        tick     <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = display_after(t);
        expected_views.push_back(typed ? want : predicted);
    endtask

    // Period writes go in only once every pending result has been seen.
    task automatic write_period(input cfg_index_t sel, input logic [PERIOD_W-1:0] value);
        in_valid <= 1'b0;
        while (expected_views.size() != 0)
            @(posedge clk);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (sel)
            CFG_BLINK_PERIOD:  blink_reload  = value;
            CFG_SECOND_PERIOD: second_reload = value;
            CFG_SCAN_PERIOD:   scan_reload   = value;
            default:           ;
        endcase
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n === 1'b1 && out_valid && !out_stall)
        begin
            got = {segments, digit_enables, dot_led, red_led,
                   hours_now, minutes_now, seconds_now};
            if (expected_views.size() == 0)
            begin
                flag_fault($sformatf("unexpected result transfer %h", got));
            end
            else
            begin
                want = expected_views.pop_front();
                if (got !== want)
                    flag_fault($sformatf({"mismatch (expected/actual): seg %h/%h en %h/%h ",
                        "dot %b/%b red %b/%b time %0d:%0d:%0d / %0d:%0d:%0d"},
                        want.segments, got.segments, want.digit_enables, got.digit_enables,
                        want.dot_led, got.dot_led, want.red_led, got.red_led,
                        want.hours_now, want.minutes_now, want.seconds_now,
                        got.hours_now, got.minutes_now, got.seconds_now));
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_multiplexed_seven_segment_clock: FAIL");
        $finish;
    end

    initial
    begin
        script_row_t row;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        tick      <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_BLINK_PERIOD;
        cfg_data  <= '0;
        reset_clock_model();

        script[0]  = '{ROW_TICK,  1'b0, 1,  CFG_BLINK_PERIOD,  16'h0000, 1'b1, RESET_VIEW};
        script[1]  = '{ROW_TICK,  1'b1, 1,  CFG_BLINK_PERIOD,  16'h0000, 1'b1, RESET_VIEW};
        script[2]  = '{ROW_CFG,   1'b0, 0,  CFG_BLINK_PERIOD,  16'h0001, 1'b0, RESET_VIEW};
        script[3]  = '{ROW_CFG,   1'b0, 0,  CFG_SECOND_PERIOD, 16'h0001, 1'b0, RESET_VIEW};
        script[4]  = '{ROW_CFG,   1'b0, 0,  CFG_SCAN_PERIOD,   16'h0002, 1'b0, RESET_VIEW};
        // A write to the spare index must leave every period alone.
        script[5]  = '{ROW_CFG,   1'b0, 0,  CFG_UNUSED,        16'hFFFF, 1'b0, RESET_VIEW};
        script[6]  = '{ROW_BURST, 1'b1, 23, CFG_BLINK_PERIOD,  16'h0000, 1'b0, RESET_VIEW};
        script[7]  = '{ROW_TICK,  1'b1, 1,  CFG_BLINK_PERIOD,  16'h0000, 1'b1, FIRST_SCAN_VIEW};
        script[8]  = '{ROW_BURST, 1'b1, 75, CFG_BLINK_PERIOD,  16'h0000, 1'b0, RESET_VIEW};
        script[9]  = '{ROW_TICK,  1'b0, 1,  CFG_BLINK_PERIOD,  16'h0000, 1'b0, RESET_VIEW};
        script[10] = '{ROW_BURST, 1'b1, 20, CFG_BLINK_PERIOD,  16'h0000, 1'b0, RESET_VIEW};
        script[11] = '{ROW_CFG,   1'b0, 0,  CFG_SECOND_PERIOD, 16'h0000, 1'b0, RESET_VIEW};
        script[12] = '{ROW_CFG,   1'b0, 0,  CFG_BLINK_PERIOD,  16'h0007, 1'b0, RESET_VIEW};
        script[13] = '{ROW_CFG,   1'b0, 0,  CFG_SCAN_PERIOD,   16'h0000, 1'b0, RESET_VIEW};
        script[14] = '{ROW_BURST, 1'b1, 8,  CFG_BLINK_PERIOD,  16'h0000, 1'b0, RESET_VIEW};
        script[15] = '{ROW_TICK,  1'b0, 1,  CFG_BLINK_PERIOD,  16'h0000, 1'b0, RESET_VIEW};
        script[16] = '{ROW_CFG,   1'b0, 0,  CFG_BLINK_PERIOD,  16'h0000, 1'b0, RESET_VIEW};
        script[17] = '{ROW_CFG,   1'b0, 0,  CFG_SCAN_PERIOD,   16'h0003, 1'b0, RESET_VIEW};
        script[18] = '{ROW_CFG,   1'b0, 0,  CFG_SECOND_PERIOD, 16'h0004, 1'b0, RESET_VIEW};
        script[19] = '{ROW_BURST, 1'b1, 6,  CFG_BLINK_PERIOD,  16'h0000, 1'b0, RESET_VIEW};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            row = script[i];
            case (row.kind)
                ROW_TICK:  send_tick(row.tick_bit, row.typed, row.want);
                ROW_BURST: repeat (row.reps) send_tick(1'b1, 1'b0, RESET_VIEW);
                default:   write_period(row.reg_sel, row.value);
            endcase
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    sender_gap_pct     <= 18;
                    receiver_stall_pct <= 83;
                end
                1:
                begin
                    sender_gap_pct     <= 83;
                    receiver_stall_pct <= 18;
                end
                default:
                begin
                    sender_gap_pct     <= 0;
                    receiver_stall_pct <= 0;
                end
            endcase
            write_period(CFG_BLINK_PERIOD, pick_period());
            write_period(CFG_SECOND_PERIOD, pick_period());
            write_period(CFG_SCAN_PERIOD, pick_period());
            if ($urandom_range(1) != 0)
                write_period(CFG_UNUSED, PERIOD_W'($urandom));
            repeat (ITEMS_PER_PHASE)
                send_tick($urandom_range(99) < 80, 1'b0, RESET_VIEW);
        end

        // Run the clock one second per tick for a stretch.
        write_period(CFG_BLINK_PERIOD, 16'd1);
        write_period(CFG_SECOND_PERIOD, 16'd1);
        write_period(CFG_SCAN_PERIOD, 16'd1);
        repeat (FAST_TAIL_ITEMS)
            send_tick($urandom_range(19) != 0, 1'b0, RESET_VIEW);

        // Full-width periods come last, since a reload from them keeps the dividers from firing again.
        write_period(CFG_BLINK_PERIOD, 16'hFFFF);
        write_period(CFG_SECOND_PERIOD, 16'hFFFF);
        write_period(CFG_SCAN_PERIOD, 16'hFFFF);
        repeat (WIDE_TAIL_ITEMS)
            send_tick(1'b1, 1'b0, RESET_VIEW);

        in_valid <= 1'b0;
        while (expected_views.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fault_count == 0)
            $display("tb_multiplexed_seven_segment_clock: PASS");
        else
            $display("tb_multiplexed_seven_segment_clock: FAIL");
        $finish;
    end

endmodule
